@@ rtl/wtkz_pkg.sv @@
// Shared types, constants and helper functions for the weighted top-k zero picker.
`default_nettype none

package wtkz_pkg;

    // Record geometry
    localparam int SLOTS   = 7;
    localparam int EV_W    = 32;
    localparam int IDX_W   = 32;
    localparam int QUOTA_W = 10;
    localparam int WGT_W   = 3;

    // One heap entry: key, slot bits, record index
    typedef struct packed {
        logic [EV_W-1:0]  key;
        logic [SLOTS-1:0] bits;
        logic [IDX_W-1:0] idx;
    } t_entry;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_PU_STEP,
        S_PU_CMP,
        S_EV_RD,
        S_EV_CMP,
        S_PO_TOP,
        S_PO_LAST,
        S_PO_KIDS,
        S_PO_L,
        S_PO_R,
        S_EMIT
    } t_state;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MARK_EMPTY,
        OP_PUSH_INIT,
        OP_RD_PARENT,
        OP_SIFT_UP,
        OP_PUT_HOLD,
        OP_RD_TOP,
        OP_TAKE_TOP,
        OP_TAKE_LAST,
        OP_RD_LEFT,
        OP_TAKE_LEFT,
        OP_SIFT_DOWN,
        OP_EMIT
    } t_op;

    // Datapath status toward the controller
    typedef struct packed {
        logic is_pop;
        logic cnt_zero;
        logic full;
        logic bits_zero;
        logic i_zero;
        logic has_l;
        logic up_move;
        logic down_move;
        logic evict;
        logic out_busy;
    } t_stat;

    // Number of set slot bits
    function automatic logic [WGT_W-1:0] weight(input logic [SLOTS-1:0] b);
        logic [WGT_W-1:0] w;
        w = '0;
        for (int j = 0; j < SLOTS; j++) begin
            w = w + WGT_W'(b[j]);
        end
        return w;
    endfunction

    // True when entry a leaves the heap before entry b
    function automatic logic ahead(input t_entry a, input t_entry b);
        logic r;
        if (a.key != b.key) begin
            r = (a.key < b.key);
        end else begin
            r = (a.idx < b.idx);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/wtkz_dp.sv @@
// Datapath: heap memory, sift registers, weight bookkeeping and result register.
`default_nettype none

module wtkz_dp #(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire wtkz_pkg::t_op                          i_op,
    output wtkz_pkg::t_stat                             o_stat,
    input  wire logic                                   i_cfg_we,
    input  wire logic [wtkz_pkg::QUOTA_W-1:0]           i_cfg_wdata,
    input  wire logic                                   i_action,
    input  wire logic [wtkz_pkg::IDX_W-1:0]             i_item_index,
    input  wire logic [wtkz_pkg::SLOTS-1:0]             i_prior_mask,
    input  wire logic [wtkz_pkg::SLOTS-1:0][wtkz_pkg::EV_W-1:0] i_ev,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output logic [wtkz_pkg::IDX_W-1:0]                  o_picked_index,
    output logic [wtkz_pkg::SLOTS-1:0]                  o_new_bits,
    output logic                                        o_heap_empty
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int RW = $clog2(HEAP_DEPTH * wtkz_pkg::SLOTS + 1);
    localparam int SW = (RW > wtkz_pkg::QUOTA_W + 1) ? RW : wtkz_pkg::QUOTA_W + 1;
    localparam int LW = AW + 2;

    // Heap storage
    wtkz_pkg::t_entry r_mem [HEAP_DEPTH];
    wtkz_pkg::t_entry r_rd;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;
    wtkz_pkg::t_entry wr_data;

    // Control and payload registers
    logic [CW-1:0]                 r_count, n_count;
    logic [RW-1:0]                 r_retained, n_retained;
    logic [wtkz_pkg::QUOTA_W-1:0]  r_quota;
    logic [AW-1:0]                 r_i, n_i;
    wtkz_pkg::t_entry              r_new;
    logic                          r_is_pop;
    wtkz_pkg::t_entry              r_hold, r_rl, r_top;
    logic                          r_empty;
    logic                          r_out_valid;

    // Derived values
    logic [wtkz_pkg::SLOTS-1:0]    ld_bits;
    logic [wtkz_pkg::EV_W-1:0]     ld_key;
    logic [AW-1:0]                 parent;
    logic [LW-1:0]                 lchild, rchild, count_x;
    logic                          has_r;
    logic                          pick_l, pick_r;
    wtkz_pkg::t_entry              best;
    logic [SW-1:0]                 need;

    // Slot scan of the incoming record
    always_comb begin
        ld_bits = '0;
        ld_key  = '0;
        for (int j = 0; j < wtkz_pkg::SLOTS; j++) begin
            ld_bits[j] = (i_ev[j] == '0) && !i_prior_mask[j];
            if (i_ev[j] > ld_key) begin
                ld_key = i_ev[j];
            end
        end
    end

    // Tree navigation
    assign parent  = (r_i - AW'(1)) >> 1;
    assign lchild  = {1'b0, r_i, 1'b1};
    assign rchild  = lchild + LW'(1);
    assign count_x = LW'(r_count);
    assign has_r   = rchild < count_x;

    // Sift-down child selection
    always_comb begin
        pick_l = o_stat.has_l && wtkz_pkg::ahead(r_rl, r_hold);
        best   = pick_l ? r_rl : r_hold;
        pick_r = has_r && wtkz_pkg::ahead(r_rd, best);
        if (pick_r) begin
            best = r_rd;
        end
    end

    assign need = SW'(r_quota) + SW'(wtkz_pkg::weight(r_rd.bits));

    // Status
    always_comb begin
        o_stat.is_pop    = r_is_pop;
        o_stat.cnt_zero  = (r_count == '0);
        o_stat.full      = (r_count >= CW'(HEAP_DEPTH));
        o_stat.bits_zero = (r_new.bits == '0);
        o_stat.i_zero    = (r_i == '0);
        o_stat.has_l     = lchild < count_x;
        o_stat.up_move   = wtkz_pkg::ahead(r_hold, r_rd);
        o_stat.down_move = pick_l || pick_r;
        o_stat.evict     = SW'(r_retained) >= need;
        o_stat.out_busy  = r_out_valid && !i_out_ready;
    end

    // Memory port control and next values
    always_comb begin
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_data    = r_hold;
        n_count    = r_count;
        n_retained = r_retained;
        n_i        = r_i;
        unique case (i_op)
            wtkz_pkg::OP_PUSH_INIT: begin
                n_i        = r_count[AW-1:0];
                n_count    = r_count + CW'(1);
                n_retained = r_retained + RW'(wtkz_pkg::weight(r_new.bits));
            end
            wtkz_pkg::OP_RD_PARENT: begin
                rd_en   = 1'b1;
                rd_addr = parent;
            end
            wtkz_pkg::OP_SIFT_UP: begin
                wr_en = 1'b1;
                if (o_stat.up_move) begin
                    wr_data = r_rd;
                    n_i     = parent;
                end
            end
            wtkz_pkg::OP_PUT_HOLD: begin
                wr_en = 1'b1;
            end
            wtkz_pkg::OP_RD_TOP: begin
                rd_en = 1'b1;
            end
            wtkz_pkg::OP_TAKE_TOP: begin
                n_count    = r_count - CW'(1);
                n_retained = r_retained - RW'(wtkz_pkg::weight(r_rd.bits));
                rd_en      = 1'b1;
                rd_addr    = n_count[AW-1:0];
            end
            wtkz_pkg::OP_TAKE_LAST: begin
                n_i = '0;
            end
            wtkz_pkg::OP_RD_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = lchild[AW-1:0];
            end
            wtkz_pkg::OP_TAKE_LEFT: begin
                rd_en   = 1'b1;
                rd_addr = rchild[AW-1:0];
            end
            wtkz_pkg::OP_SIFT_DOWN: begin
                wr_en = 1'b1;
                if (pick_r) begin
                    wr_data = r_rd;
                    n_i     = rchild[AW-1:0];
                end else if (pick_l) begin
                    wr_data = r_rl;
                    n_i     = lchild[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Heap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_i] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_retained  <= '0;
            r_quota     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_retained <= n_retained;
            if (i_cfg_we) begin
                r_quota <= i_cfg_wdata;
            end
            if (i_op == wtkz_pkg::OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        unique case (i_op)
            wtkz_pkg::OP_LOAD: begin
                r_is_pop   <= i_action;
                r_new.key  <= ld_key;
                r_new.bits <= ld_bits;
                r_new.idx  <= i_item_index;
            end
            wtkz_pkg::OP_PUSH_INIT: begin
                r_hold <= r_new;
            end
            wtkz_pkg::OP_MARK_EMPTY: begin
                r_empty <= 1'b1;
            end
            wtkz_pkg::OP_TAKE_TOP: begin
                r_top   <= r_rd;
                r_empty <= 1'b0;
            end
            wtkz_pkg::OP_TAKE_LAST: begin
                r_hold <= r_rd;
            end
            wtkz_pkg::OP_TAKE_LEFT: begin
                r_rl <= r_rd;
            end
            wtkz_pkg::OP_EMIT: begin
                o_picked_index <= r_empty ? '0 : r_top.idx;
                o_new_bits     <= r_empty ? '0 : r_top.bits;
                o_heap_empty   <= r_empty;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/wtkz_ctrl.sv @@
// Controller: sequences offers, evictions and drains over the heap datapath.
`default_nettype none

module wtkz_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire wtkz_pkg::t_stat i_stat,
    output wtkz_pkg::t_op        o_op
);

    wtkz_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wtkz_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wtkz_pkg::S_IDLE: begin
                if (i_in_valid) n_state = wtkz_pkg::S_DECIDE;
            end
            wtkz_pkg::S_DECIDE: begin
                if (i_stat.is_pop) begin
                    n_state = i_stat.cnt_zero ? wtkz_pkg::S_EMIT : wtkz_pkg::S_PO_TOP;
                end else if (i_stat.bits_zero || i_stat.full) begin
                    n_state = wtkz_pkg::S_IDLE;
                end else begin
                    n_state = wtkz_pkg::S_PU_STEP;
                end
            end
            wtkz_pkg::S_PU_STEP: begin
                n_state = i_stat.i_zero ? wtkz_pkg::S_EV_RD : wtkz_pkg::S_PU_CMP;
            end
            wtkz_pkg::S_PU_CMP: begin
                n_state = i_stat.up_move ? wtkz_pkg::S_PU_STEP : wtkz_pkg::S_EV_RD;
            end
            wtkz_pkg::S_EV_RD: begin
                n_state = i_stat.cnt_zero ? wtkz_pkg::S_IDLE : wtkz_pkg::S_EV_CMP;
            end
            wtkz_pkg::S_EV_CMP: begin
                n_state = i_stat.evict ? wtkz_pkg::S_PO_LAST : wtkz_pkg::S_IDLE;
            end
            wtkz_pkg::S_PO_TOP:  n_state = wtkz_pkg::S_PO_LAST;
            wtkz_pkg::S_PO_LAST: n_state = wtkz_pkg::S_PO_KIDS;
            wtkz_pkg::S_PO_KIDS: begin
                if (i_stat.has_l) begin
                    n_state = wtkz_pkg::S_PO_L;
                end else begin
                    n_state = i_stat.is_pop ? wtkz_pkg::S_EMIT : wtkz_pkg::S_EV_RD;
                end
            end
            wtkz_pkg::S_PO_L: n_state = wtkz_pkg::S_PO_R;
            wtkz_pkg::S_PO_R: begin
                if (i_stat.down_move) begin
                    n_state = wtkz_pkg::S_PO_KIDS;
                end else begin
                    n_state = i_stat.is_pop ? wtkz_pkg::S_EMIT : wtkz_pkg::S_EV_RD;
                end
            end
            wtkz_pkg::S_EMIT: begin
                if (!i_stat.out_busy) n_state = wtkz_pkg::S_IDLE;
            end
            default: n_state = wtkz_pkg::S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_op       = wtkz_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            wtkz_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_op = wtkz_pkg::OP_LOAD;
            end
            wtkz_pkg::S_DECIDE: begin
                if (i_stat.is_pop) begin
                    o_op = i_stat.cnt_zero ? wtkz_pkg::OP_MARK_EMPTY : wtkz_pkg::OP_RD_TOP;
                end else if (!(i_stat.bits_zero || i_stat.full)) begin
                    o_op = wtkz_pkg::OP_PUSH_INIT;
                end
            end
            wtkz_pkg::S_PU_STEP: begin
                o_op = i_stat.i_zero ? wtkz_pkg::OP_PUT_HOLD : wtkz_pkg::OP_RD_PARENT;
            end
            wtkz_pkg::S_PU_CMP: o_op = wtkz_pkg::OP_SIFT_UP;
            wtkz_pkg::S_EV_RD: begin
                if (!i_stat.cnt_zero) o_op = wtkz_pkg::OP_RD_TOP;
            end
            wtkz_pkg::S_EV_CMP: begin
                if (i_stat.evict) o_op = wtkz_pkg::OP_TAKE_TOP;
            end
            wtkz_pkg::S_PO_TOP:  o_op = wtkz_pkg::OP_TAKE_TOP;
            wtkz_pkg::S_PO_LAST: o_op = wtkz_pkg::OP_TAKE_LAST;
            wtkz_pkg::S_PO_KIDS: begin
                o_op = i_stat.has_l ? wtkz_pkg::OP_RD_LEFT : wtkz_pkg::OP_PUT_HOLD;
            end
            wtkz_pkg::S_PO_L: o_op = wtkz_pkg::OP_TAKE_LEFT;
            wtkz_pkg::S_PO_R: o_op = wtkz_pkg::OP_SIFT_DOWN;
            wtkz_pkg::S_EMIT: begin
                if (!i_stat.out_busy) o_op = wtkz_pkg::OP_EMIT;
            end
            default: o_op = wtkz_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/weighted_top_k_zero_picker_core.sv @@
// Top level of the weighted top-k zero picker.
`default_nettype none

// Keeps the highest-evaluated records of a stream in a min-heap held in a
// single-port memory (one write and one registered read a cycle). An offer
// beat is decoded, then the new entry climbs the heap level by level, each
// step reading the parent and comparing, until it is placed, then the root is
// checked for an eviction. Each eviction takes the root, moves the last entry
// to the root and sinks it level by level, and is followed by another check.
// An offer with no zero unpicked slot, or one arriving at a full heap,
// finishes after decode. A pop beat takes the root and sinks the last entry
// in the same way, then may wait for the output register; a pop of an empty
// heap only reports o_heap_empty. A new beat is taken as soon as the previous
// one is done, even if its result still waits on the output. The heap needs
// no clearing after reset. The user must write high_quota through
// i_cfg_we/i_cfg_wdata only while idle; the block does not enforce this.
module weighted_top_k_zero_picker_core #(
    parameter int HEAP_DEPTH = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [9:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_item_index,
    input  wire logic [6:0]  i_prior_mask,
    input  wire logic [31:0] i_ev_0,
    input  wire logic [31:0] i_ev_1,
    input  wire logic [31:0] i_ev_2,
    input  wire logic [31:0] i_ev_3,
    input  wire logic [31:0] i_ev_4,
    input  wire logic [31:0] i_ev_5,
    input  wire logic [31:0] i_ev_6,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_picked_index,
    output logic [6:0]       o_new_bits,
    output logic             o_heap_empty
);

    wtkz_pkg::t_op   op;
    wtkz_pkg::t_stat stat;
    logic [wtkz_pkg::SLOTS-1:0][wtkz_pkg::EV_W-1:0] ev;

    assign ev = {i_ev_6, i_ev_5, i_ev_4, i_ev_3, i_ev_2, i_ev_1, i_ev_0};

    wtkz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_op       (op)
    );

    wtkz_dp #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_item_index   (i_item_index),
        .i_prior_mask   (i_prior_mask),
        .i_ev           (ev),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_picked_index (o_picked_index),
        .o_new_bits     (o_new_bits),
        .o_heap_empty   (o_heap_empty)
    );

endmodule

`default_nettype wire
